// ===== hw/rtl/bzcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bzcd_pkg: shared types and constants for the back-EMF zero-crossing detector
// Item, state and result layouts, register indexes, limits.
// ----------------------------------------------------------------------------
package bzcd_pkg;

  localparam int TIMER_W    = 16;
  localparam int STEP_W     = 3;
  localparam int CNT_W      = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]   CROSS_MAX      = CNT_W'(10000);
  localparam logic [TIMER_W-1:0] OFFSET_DEFAULT = TIMER_W'(133);

  // tdata layouts, lowest bit first
  localparam int IN_BITS     = STEP_W + 3 + 2 * TIMER_W + 1;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 + 4 * TIMER_W + CNT_W + 1;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_ENABLE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_OFFSET = CFG_IDX_W'(1);

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_REARM = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    HIST_LOW     = 2'd0,
    HIST_HIGH    = 2'd1,
    HIST_INVALID = 2'd2
  } hist_t;

  typedef struct packed {
    func_t               func;
    logic [STEP_W-1:0]   step;
    logic                comp_a;
    logic                comp_b;
    logic                comp_c;
    logic [TIMER_W-1:0]  timer_count;
    logic [TIMER_W-1:0]  timer_period;
    logic                motor_running;
  } item_t;

  typedef struct packed {
    hist_t [2:0]         hist;
    logic                lockout;
    logic                us_checked;
    logic [CNT_W-1:0]    crossings;
    logic [TIMER_W-1:0]  elapsed_latest;
    logic [TIMER_W-1:0]  elapsed_before;
    logic [TIMER_W-1:0]  period_latest;
    logic [TIMER_W-1:0]  period_before;
  } state_t;

  typedef struct packed {
    logic                crossing_event;
    logic                undershoot_event;
    logic [TIMER_W-1:0]  elapsed_capture;
    logic [TIMER_W-1:0]  previous_capture;
    logic [TIMER_W-1:0]  period_capture;
    logic [TIMER_W-1:0]  previous_period;
    logic [CNT_W-1:0]    crossing_count;
    logic                locked_out;
  } result_t;

endpackage

// ===== hw/rtl/bzcd_eval.sv =====
// ----------------------------------------------------------------------------
// bzcd_eval: per-item evaluation
// Next detector state and result for one item, purely combinational.
// ----------------------------------------------------------------------------
module bzcd_eval (
  input  bzcd_pkg::item_t                 item,
  input  bzcd_pkg::state_t                cur,
  input  logic                            detect_enable,
  input  logic [bzcd_pkg::TIMER_W-1:0]    capture_offset,
  output bzcd_pkg::state_t                nxt,
  output bzcd_pkg::result_t               res
);
  import bzcd_pkg::*;

  logic               active;
  logic [1:0]         sel;
  logic [1:0]         inval;
  logic               rising;
  logic               comp_now;
  hist_t              old;
  logic               at_after;
  logic               was_before;
  logic [TIMER_W-1:0] eighth;
  logic [TIMER_W-1:0] win_hi;
  logic [TIMER_W-1:0] cap;
  logic               cross_ev;
  logic               under_ev;

  // floating phase: steps 1,4 -> a; 2,5 -> b; 3,6 -> c
  always_comb begin
    active = 1'b1;
    sel    = 2'd0;
    case (item.step)
      3'd1, 3'd4: sel = 2'd0;
      3'd2, 3'd5: sel = 2'd1;
      3'd3, 3'd6: sel = 2'd2;
      default:    active = 1'b0;
    endcase
    case (sel)
      2'd0:    inval = 2'd2;
      2'd1:    inval = 2'd0;
      default: inval = 2'd1;
    endcase
  end

  always_comb begin
    case (sel)
      2'd0:    comp_now = item.comp_a;
      2'd1:    comp_now = item.comp_b;
      default: comp_now = item.comp_c;
    endcase
  end

  assign rising     = item.step[0];
  assign old        = cur.hist[sel];
  assign at_after   = (comp_now == rising);
  assign was_before = (old == (rising ? HIST_LOW : HIST_HIGH));
  assign eighth     = item.timer_period >> 3;
  assign win_hi     = item.timer_period - (item.timer_period >> 4);
  assign cap        = item.timer_count - capture_offset;

  always_comb begin
    nxt      = cur;
    cross_ev = 1'b0;
    under_ev = 1'b0;
    if (item.func == FUNC_REARM) begin
      nxt.lockout    = 1'b0;
      nxt.us_checked = 1'b0;
    end else if (detect_enable && active) begin
      nxt.hist[inval] = HIST_INVALID;
      nxt.hist[sel]   = comp_now ? HIST_HIGH : HIST_LOW;

      // once-per-step undershoot check
      if ((item.timer_count > eighth) && item.motor_running && !cur.us_checked) begin
        if (at_after && !cur.lockout) begin
          nxt.elapsed_before = cur.elapsed_latest;
          nxt.period_before  = cur.period_latest;
          nxt.elapsed_latest = eighth;
          nxt.period_latest  = item.timer_period;
          nxt.lockout        = 1'b1;
          under_ev           = 1'b1;
        end
        nxt.us_checked = 1'b1;
      end

      // qualified edge; lockout from an undershoot on this tick blocks it
      if (at_after && was_before && !nxt.lockout) begin
        nxt.elapsed_before = nxt.elapsed_latest;
        nxt.elapsed_latest = cap;
        nxt.period_latest  = item.timer_period;
        if ((cap > eighth) && (cap < win_hi)) begin
          nxt.lockout = 1'b1;
          cross_ev    = 1'b1;
          if (cur.crossings < CROSS_MAX) begin
            nxt.crossings = cur.crossings + CNT_W'(1);
          end
        end
      end
    end
  end

  assign res.crossing_event   = cross_ev;
  assign res.undershoot_event = under_ev;
  assign res.elapsed_capture  = nxt.elapsed_latest;
  assign res.previous_capture = nxt.elapsed_before;
  assign res.period_capture   = nxt.period_latest;
  assign res.previous_period  = nxt.period_before;
  assign res.crossing_count   = nxt.crossings;
  assign res.locked_out       = nxt.lockout;

endmodule

// ===== hw/rtl/bemf_zero_crossing_detector.sv =====
// ----------------------------------------------------------------------------
// bemf_zero_crossing_detector: sensorless BLDC back-EMF zero-crossing detector
// Input register, combinational evaluation against the detector state, and an
// output register; one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Path: the input register feeds the evaluation, whose result is held in the output register on m_tdata.
// Throughput: one transaction per cycle; the input register and the state
//   update take a new item every cycle unless the output register is full
//   and m_tready is low.
// Reset (rst, synchronous, active high): pipeline empty, history invalid,
//   lockout, captures and count cleared, detect_enable 0, offset 133.
module bemf_zero_crossing_detector (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [2:0] step, [3] comp_a, [4] comp_b, [5] comp_c, [21:6] timer_count,
  // [37:22] timer_period, [38] motor_running, [39] zero
  input  logic [bzcd_pkg::IN_DATA_W-1:0]     s_tdata,
  // [0] func (0 PWM tick, 1 rearm)
  input  logic                               s_tuser,
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] crossing_event, [1] undershoot_event, [17:2] elapsed_capture,
  // [33:18] previous_capture, [49:34] period_capture, [65:50] previous_period,
  // [79:66] crossing_count, [80] locked_out, [87:81] zero
  output logic [bzcd_pkg::OUT_DATA_W-1:0]    m_tdata,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bzcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bzcd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bzcd_pkg::*;

  // configuration registers
  logic               detect_enable;
  logic [TIMER_W-1:0] capture_offset;

  // pipeline
  logic    in_valid;
  item_t   in_item;
  item_t   s_item;
  logic    out_valid;
  result_t out_res;
  logic    advance;

  // detector state
  state_t  state;
  state_t  state_next;
  result_t res_next;

  // Unpack the slave tdata/tuser into the item struct.
  assign s_item.func          = func_t'(s_tuser);
  assign s_item.step          = s_tdata[STEP_W-1:0];
  assign s_item.comp_a        = s_tdata[STEP_W];
  assign s_item.comp_b        = s_tdata[STEP_W+1];
  assign s_item.comp_c        = s_tdata[STEP_W+2];
  assign s_item.timer_count   = s_tdata[STEP_W+3 +: TIMER_W];
  assign s_item.timer_period  = s_tdata[STEP_W+3+TIMER_W +: TIMER_W];
  assign s_item.motor_running = s_tdata[STEP_W+3+2*TIMER_W];

  // The item in the input register moves to the output register whenever
  // that register is empty or being drained this cycle; the state is
  // updated on the same edge, so back-to-back items see each other's state.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= s_item;
    end
  end

  bzcd_eval u_eval (
    .item           (in_item),
    .cur            (state),
    .detect_enable  (detect_enable),
    .capture_offset (capture_offset),
    .nxt            (state_next),
    .res            (res_next)
  );

  // Detector state: only touched when an item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.hist           <= '{HIST_INVALID, HIST_INVALID, HIST_INVALID};
      state.lockout        <= 1'b0;
      state.us_checked     <= 1'b0;
      state.crossings      <= '0;
      state.elapsed_latest <= '0;
      state.elapsed_before <= '0;
      state.period_latest  <= '0;
      state.period_before  <= '0;
    end else if (in_valid && advance) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'({out_res.locked_out, out_res.crossing_count,
                                 out_res.previous_period, out_res.period_capture,
                                 out_res.previous_capture, out_res.elapsed_capture,
                                 out_res.undershoot_event, out_res.crossing_event});

  // Configuration: always ready; the user must write only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_enable  <= 1'b0;
      capture_offset <= OFFSET_DEFAULT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DETECT_ENABLE:  detect_enable  <= cfg_data[0];
        REG_CAPTURE_OFFSET: capture_offset <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An undershoot on a tick locks out the edge, so both never report together.
  a_single_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.crossing_event && out_res.undershoot_event))
    else $error("crossing and undershoot in one result");

  // Any reported event leaves the lockout set.
  a_event_locks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.crossing_event || out_res.undershoot_event))
      |-> out_res.locked_out)
    else $error("event reported without lockout");

  // Crossing counter saturates.
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    state.crossings <= CROSS_MAX)
    else $error("crossing count past saturation");

  // A stalled item in the input register leaves the detector state alone.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> $stable(state))
    else $error("state changed while stalled");

endmodule

// ===== bench/tb_bemf_zero_crossing_detector.sv =====
// ----------------------------------------------------------------------------
// tb_bemf_zero_crossing_detector: self-checking bench for the back-EMF
// zero-crossing detector
// Drives PWM-tick and rearm transactions with random gaps and output stalls.
// An internal copy of the detector state predicts every result transaction,
// and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb_bemf_zero_crossing_detector;
  import bzcd_pkg::*;

  // Expected-behavior tracker: mirrors detector state and registers, predicts
  // one report per accepted sample, and checks reports in arrival order.
  class zc_tracker;
    logic                 detect_en;
    logic [TIMER_W-1:0]   cap_offset;
    hist_t                hist[3];
    logic                 lockout;
    logic                 us_checked;
    logic [CNT_W-1:0]     crossings;
    logic [TIMER_W-1:0]   el_latest;
    logic [TIMER_W-1:0]   el_before;
    logic [TIMER_W-1:0]   per_latest;
    logic [TIMER_W-1:0]   per_before;
    result_t              due_reports[$];
    int                   faults;
    int                   shown;
    int                   reports_seen;

    function new();
      detect_en  = 1'b0;
      cap_offset = OFFSET_DEFAULT;
      foreach (hist[i]) hist[i] = HIST_INVALID;
      lockout    = 1'b0;
      us_checked = 1'b0;
      crossings  = '0;
      el_latest  = '0;
      el_before  = '0;
      per_latest = '0;
      per_before = '0;
      faults     = 0;
      shown      = 0;
      reports_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DETECT_ENABLE) detect_en = data[0];
      else if (idx == REG_CAPTURE_OFFSET) cap_offset = data;
    endfunction

    // advance the detector copy by one accepted sample, queue its report
    function void note_sample(item_t it);
      result_t            r;
      int                 sel;
      int                 inval;
      logic [2:0]         lv;
      hist_t              after_lvl;
      hist_t              prior_lvl;
      hist_t              old;
      hist_t              now;
      logic [TIMER_W-1:0] per8;
      r = '0;
      if (it.func == FUNC_REARM) begin
        lockout    = 1'b0;
        us_checked = 1'b0;
      end else if (detect_en && it.step >= 1 && it.step <= 6) begin
        // steps 1,4 watch a; 2,5 watch b; 3,6 watch c
        sel   = (int'(it.step) - 1) % 3;
        inval = (sel + 2) % 3;
        lv    = {it.comp_c, it.comp_b, it.comp_a};
        if (it.step[0]) begin
          after_lvl = HIST_HIGH;
          prior_lvl = HIST_LOW;
        end else begin
          after_lvl = HIST_LOW;
          prior_lvl = HIST_HIGH;
        end
        hist[inval] = HIST_INVALID;
        old = hist[sel];
        if (lv[sel]) now = HIST_HIGH;
        else now = HIST_LOW;
        hist[sel] = now;
        per8 = it.timer_period >> 3;

        // once per step: comparator already past the crossing
        if (it.timer_count > per8 && it.motor_running && !us_checked) begin
          if (now == after_lvl && !lockout) begin
            el_before  = el_latest;
            per_before = per_latest;
            el_latest  = per8;
            per_latest = it.timer_period;
            lockout    = 1'b1;
            r.undershoot_event = 1'b1;
          end
          us_checked = 1'b1;
        end

        // qualified edge: capture always, event only inside the window
        if (now == after_lvl && old == prior_lvl && !lockout) begin
          el_before  = el_latest;
          el_latest  = it.timer_count - cap_offset;
          per_latest = it.timer_period;
          if (el_latest > per8 &&
              el_latest < it.timer_period - (it.timer_period >> 4)) begin
            lockout = 1'b1;
            r.crossing_event = 1'b1;
            if (crossings < CROSS_MAX) crossings = crossings + 1'b1;
          end
        end
      end
      r.elapsed_capture  = el_latest;
      r.previous_capture = el_before;
      r.period_capture   = per_latest;
      r.previous_period  = per_before;
      r.crossing_count   = crossings;
      r.locked_out       = lockout;
      due_reports.push_back(r);
    endfunction

    function void check_report(logic [OUT_DATA_W-1:0] w);
      result_t want;
      result_t got;
      string   bad;
      got.crossing_event   = w[0];
      got.undershoot_event = w[1];
      got.elapsed_capture  = w[17:2];
      got.previous_capture = w[33:18];
      got.period_capture   = w[49:34];
      got.previous_period  = w[65:50];
      got.crossing_count   = w[79:66];
      got.locked_out       = w[80];
      reports_seen++;
      if (due_reports.size() == 0) begin
        faults++;
        if (shown < 10) begin
          shown++;
          $display("report %0d arrived with nothing pending: %h", reports_seen, w);
        end
        return;
      end
      want = due_reports.pop_front();
      bad = "";
      if (got.crossing_event !== want.crossing_event)     bad = {bad, " crossing_event"};
      if (got.undershoot_event !== want.undershoot_event) bad = {bad, " undershoot_event"};
      if (got.elapsed_capture !== want.elapsed_capture)   bad = {bad, " elapsed_capture"};
      if (got.previous_capture !== want.previous_capture) bad = {bad, " previous_capture"};
      if (got.period_capture !== want.period_capture)     bad = {bad, " period_capture"};
      if (got.previous_period !== want.previous_period)   bad = {bad, " previous_period"};
      if (got.crossing_count !== want.crossing_count)     bad = {bad, " crossing_count"};
      if (got.locked_out !== want.locked_out)             bad = {bad, " locked_out"};
      if (bad != "") begin
        faults++;
        if (shown < 10) begin
          shown++;
          $display("report %0d mismatch in%s", reports_seen, bad);
          $display("  exp ce=%0b ue=%0b el=%0d pc=%0d pp=%0d pv=%0d cnt=%0d lk=%0b",
                   want.crossing_event, want.undershoot_event, want.elapsed_capture,
                   want.previous_capture, want.period_capture, want.previous_period,
                   want.crossing_count, want.locked_out);
          $display("  got ce=%0b ue=%0b el=%0d pc=%0d pp=%0d pv=%0d cnt=%0d lk=%0b",
                   got.crossing_event, got.undershoot_event, got.elapsed_capture,
                   got.previous_capture, got.period_capture, got.previous_period,
                   got.crossing_count, got.locked_out);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  logic                    s_tuser = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  zc_tracker book;
  int        sent = 0;       // accepted input transactions
  bit        tx_busy = 1'b1; // sender inserts gaps when set
  bit        rx_busy = 1'b1; // receiver inserts stalls when set
  bit        rx_idle_ok = 1'b1;
  bit        hold_req = 1'b0;
  logic      rx_hold = 1'b0;
  int        rx_wait = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bemf_zero_crossing_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Result side: check each transaction, then draw a random stall in stall-heavy stretches.
  // rx_hold (long back-pressure) overrides the normal stall pattern.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        book.check_report(m_tdata);
        // occasionally switch between stall-heavy and full-rate stretches
        if ($urandom_range(0, 31) == 0) rx_busy = !rx_busy;
        rx_wait = (rx_busy && rx_idle_ok) ? $urandom_range(0, 15) : 0;
      end
      if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else if (rx_hold) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted here; the sender keeps pushing meanwhile
  // so the pipeline fills and s_tready drops.
  initial begin
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Run limit: a watchdog far above the slowest legal run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [IN_DATA_W-1:0] pack_item(item_t it);
    return {1'b0, it.motor_running, it.timer_period, it.timer_count,
            it.comp_c, it.comp_b, it.comp_a, it.step};
  endfunction

  // lv is {comp_c, comp_b, comp_a}
  function automatic item_t make_tick(int stp, logic [2:0] lv, int cnt, int per, bit run);
    item_t it;
    it.func          = FUNC_TICK;
    it.step          = stp[STEP_W-1:0];
    it.comp_a        = lv[0];
    it.comp_b        = lv[1];
    it.comp_c        = lv[2];
    it.timer_count   = cnt[TIMER_W-1:0];
    it.timer_period  = per[TIMER_W-1:0];
    it.motor_running = run;
    return it;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.func          = func_t'($urandom_range(0, 1));
    it.step          = STEP_W'($urandom_range(0, 7));
    it.comp_a        = 1'($urandom_range(0, 1));
    it.comp_b        = 1'($urandom_range(0, 1));
    it.comp_c        = 1'($urandom_range(0, 1));
    it.timer_count   = TIMER_W'($urandom_range(0, 65535));
    it.timer_period  = TIMER_W'($urandom_range(0, 65535));
    it.motor_running = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // rearm carries random payload; the block must ignore it
  function automatic item_t make_rearm();
    item_t it;
    it = noise_item();
    it.func = FUNC_REARM;
    return it;
  endfunction

  function automatic int tx_gap();
    return tx_busy ? $urandom_range(0, 15) : 0;
  endfunction

  // valid is lowered only when a gap follows, so back-to-back items keep it high
  task automatic send_item(item_t it, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_item(it);
    s_tuser  <= it.func;
    do @(posedge clk); while (!s_tready);
    book.note_sample(it);
    sent++;
  endtask

  // stop offering, wait for outstanding reports (bounded), then settle
  task automatic drain();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (book.due_reports.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // both registers in one back-to-back burst; valid drops once at the end
  task automatic configure(logic en, logic [CFG_DATA_W-1:0] off);
    logic [CFG_DATA_W-1:0] en_word;
    en_word    = CFG_DATA_W'($urandom);  // upper bits are don't-care for the enable
    en_word[0] = en;
    cfg_valid <= 1'b1;
    cfg_index <= REG_DETECT_ENABLE;
    cfg_data  <= en_word;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(REG_DETECT_ENABLE, en_word);
    cfg_index <= REG_CAPTURE_OFFSET;
    cfg_data  <= off;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(REG_CAPTURE_OFFSET, off);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_period();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 65535);
      default: return $urandom_range(400, 12000);
    endcase
  endfunction

  // One commutation step as the firmware would see it: usually a rearm, then ticks with
  // a rising timer count; the watched comparator flips at a random point.
  task automatic commutation_burst(bit may_idle);
    int         per;
    int         stepn;
    int         sel;
    int         ticks;
    int         flip;
    int         cnt;
    logic [2:0] lv;
    per   = pick_period();
    stepn = $urandom_range(1, 6);
    sel   = (stepn - 1) % 3;
    ticks = $urandom_range(3, 12);
    flip  = $urandom_range(0, per);
    tx_busy = may_idle && ($urandom_range(0, 2) != 0);
    if ($urandom_range(0, 9) != 0) send_item(make_rearm(), tx_gap());
    for (int i = 0; i <= ticks; i++) begin
      cnt = (per * i) / ticks + $urandom_range(0, 31);
      if (cnt > 65535) cnt = 65535;
      lv = 3'($urandom_range(0, 7));
      // falling steps start high and end low
      lv[sel] = (cnt >= flip) ^ !stepn[0];
      if ($urandom_range(0, 15) == 0) lv[sel] = !lv[sel];  // comparator chatter
      send_item(make_tick(stepn, lv, cnt, per, $urandom_range(0, 4) != 0), tx_gap());
    end
  endtask

  task automatic run_random(int n);
    int target;
    target = sent + n;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 8) commutation_burst(1'b1);
      else send_item(noise_item(), tx_gap());
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    item_t plan[$];
    item_t it;
    book = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: detection off, so a tick leaves everything untouched
    send_item(make_tick(1, 3'b001, 1000, 8000, 1), $urandom_range(0, 15));
    send_item(make_rearm(), $urandom_range(0, 15));
    drain();

    // Directed pass with detection on, default offset
    configure(1'b1, OFFSET_DEFAULT);
    plan.push_back(make_tick(0, 3'b111, 5000, 8000, 1));   // stopped step
    plan.push_back(make_tick(7, 3'b111, 5000, 8000, 1));   // out-of-range step
    plan.push_back(make_tick(1, 3'b000, 0, 8000, 1));      // first sample, history invalid
    plan.push_back(make_tick(1, 3'b001, 2000, 8000, 0));   // rising edge inside window
    plan.push_back(make_tick(1, 3'b000, 3000, 8000, 1));   // locked out
    plan.push_back(make_rearm());
    plan.push_back(make_tick(2, 3'b010, 500, 8000, 1));    // b high, before period/8
    plan.push_back(make_tick(2, 3'b000, 3000, 8000, 1));   // undershoot and edge together
    plan.push_back(make_rearm());
    plan.push_back(make_tick(3, 3'b000, 100, 8000, 0));
    plan.push_back(make_tick(3, 3'b100, 200, 8000, 0));    // edge below window
    plan.push_back(make_tick(3, 3'b000, 100, 8000, 0));
    plan.push_back(make_tick(3, 3'b100, 7900, 8000, 0));   // edge above window
    plan.push_back(make_tick(4, 3'b001, 50, 65535, 0));
    plan.push_back(make_tick(4, 3'b000, 50, 65535, 0));    // capture wraps below zero
    plan.push_back(make_tick(5, 3'b111, 65535, 65535, 1)); // undershoot at full scale
    it = make_tick(7, 3'b111, 65535, 65535, 1);
    it.func = FUNC_REARM;                                  // rearm with all ones payload
    plan.push_back(it);
    plan.push_back(make_tick(6, 3'b000, 65535, 0, 1));     // zero period undershoot
    plan.push_back(make_rearm());
    plan.push_back(make_tick(6, 3'b100, 0, 0, 1));
    plan.push_back(make_tick(6, 3'b000, 5000, 16000, 0));  // falling edge inside window
    plan.push_back(make_rearm());
    plan.push_back(make_tick(1, 3'b000, 0, 0, 0));         // all-zero tick
    foreach (plan[i]) send_item(plan[i], $urandom_range(0, 15));
    drain();

    // Detection off again with offset at its maximum: only rearms matter
    configure(1'b0, 16'hFFFF);
    run_random(30);
    drain();

    // Zero offset; starts with the long receiver hold-off under full input
    configure(1'b1, 16'h0000);
    hold_req = 1'b1;
    repeat (3) commutation_burst(1'b0);
    run_random(130);
    drain();

    configure(1'b1, 16'hFFFF);
    run_random(130);
    drain();

    configure(1'b1, CFG_DATA_W'($urandom_range(0, 65535)));
    run_random(130);
    drain();

    configure(1'b1, OFFSET_DEFAULT);
    run_random(130);
    drain();

    // Full-rate rearm / low / high triplets, one crossing each;
    // motor not running so no undershoot interferes
    configure(1'b1, 16'h0000);
    rx_idle_ok = 1'b0;
    for (int i = 0; i < 20; i++) begin
      send_item(make_rearm(), 0);
      send_item(make_tick(1, 3'b000, 4000, 8000, 0), 0);
      send_item(make_tick(1, 3'b001, 4000, 8000, 0), 0);
    end
    rx_idle_ok = 1'b1;
    drain();

    // final settle for stray results, then verdict
    repeat (20) @(posedge clk);
    book.faults += book.due_reports.size();
    if (book.faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
